>>> rtl/tdm_pkg.sv
// ----------------------------------------------------------------------------
// tdm_pkg
// Shared types, constants and helpers of the task deadline monitor.
// ----------------------------------------------------------------------------
package tdm_pkg;

    localparam int NUM_TASKS_DEF  = 6;
    localparam int TIME_BITS_DEF  = 48;
    localparam int MAX_TASKS      = 8;
    localparam int TASK_W         = 3;
    localparam int FUNC_W         = 2;
    localparam int DEADLINE_W     = 20;
    localparam int NUM_DEADLINES  = 6;
    localparam int CFG_ADDR_W     = 3;
    localparam int STAT_W         = 32;
    localparam int S_USER_W       = FUNC_W + TASK_W;
    localparam int M_USER_W       = TASK_W + 1;
    localparam int M_DATA_W       = 4 * STAT_W;

    localparam logic [STAT_W-1:0] STAT_MAX = '1;

    localparam logic [DEADLINE_W-1:0] DEADLINE_RESET [MAX_TASKS] = '{
        20'd10000, 20'd20000, 20'd20000, 20'd50000,
        20'd50000, 20'd30000, 20'd0,     20'd0
    };

    typedef enum logic [FUNC_W-1:0] {
        FUNC_BEGIN = 2'd0,
        FUNC_END   = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIFF,
        ST_LATE,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic capture;
        logic calc_diff;
        logic calc_late;
        logic commit;
    } cmd_t;

    function automatic logic [STAT_W-1:0] sat32(input logic [63:0] v);
        logic [STAT_W-1:0] r;
        r = (v > 64'(STAT_MAX)) ? STAT_MAX : v[STAT_W-1:0];
        return r;
    endfunction

endpackage

>>> rtl/task_deadline_monitor.sv
// ----------------------------------------------------------------------------
// task_deadline_monitor
// Per-task job timing monitor: execution time, lateness, job and miss counts.
//
//   channel | group           | tdata (low bit up)                  | tuser (low bit up)
//   --------+-----------------+-------------------------------------+--------------------
//   input   | s_tvalid/tready | now_time, release_time              | func, task_id
//   output  | m_tvalid/tready | job_count, miss_count, longest_run, | task_num, job_ended
//           |                 | largest_overrun                     |
//   config  | cfg_we          | cfg_addr = register, cfg_data       | -
//
// Each word passes through capture, time differences, lateness against the
// task's deadline, then table update and output load; the sequencer runs one
// word at a time, so a new word is taken only after the previous one commits.
// A stalled output holds the commit step until the previous result drains.
// Reset zeroes all statistics and loads the default deadlines.
// ----------------------------------------------------------------------------
module task_deadline_monitor
    import tdm_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [CFG_ADDR_W-1:0]               cfg_addr,
    input  logic [DEADLINE_W-1:0]               cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // now_time, release_time, zero padding
    input  logic [((2*TIME_BITS+7)/8)*8-1:0]    s_tdata,
    // func, task_id
    input  logic [S_USER_W-1:0]                 s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // job_count, miss_count, longest_run, largest_overrun
    output logic [M_DATA_W-1:0]                 m_tdata,
    // task_num, job_ended
    output logic [M_USER_W-1:0]                 m_tuser
);

    cmd_t              cmd;
    logic [TASK_W-1:0] task_num;
    logic              job_ended;
    logic [STAT_W-1:0] job_count;
    logic [STAT_W-1:0] miss_count;
    logic [STAT_W-1:0] longest_run;
    logic [STAT_W-1:0] largest_overrun;

    tdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tdm_datapath #(
        .NUM_TASKS (NUM_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_data        (cfg_data),
        .func            (s_tuser[FUNC_W-1:0]),
        .task_id         (s_tuser[S_USER_W-1:FUNC_W]),
        .now_time        (s_tdata[TIME_BITS-1:0]),
        .release_time    (s_tdata[2*TIME_BITS-1:TIME_BITS]),
        .cmd             (cmd),
        .task_num        (task_num),
        .job_ended       (job_ended),
        .job_count       (job_count),
        .miss_count      (miss_count),
        .longest_run     (longest_run),
        .largest_overrun (largest_overrun)
    );

    assign m_tdata = {largest_overrun, longest_run, miss_count, job_count};
    assign m_tuser = {job_ended, task_num};

endmodule

>>> rtl/tdm_ctrl.sv
// ----------------------------------------------------------------------------
// tdm_ctrl
// Event sequencer: capture, time differences, lateness, commit and output
// handshake.
// ----------------------------------------------------------------------------
module tdm_ctrl
    import tdm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    output logic m_tvalid,
    input  logic m_tready,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   accept;

    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !m_tready;
        s_tready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                cmd.calc_diff = 1'b1;
                state_next    = ST_LATE;
            end
            ST_LATE:
            begin
                cmd.calc_late = 1'b1;
                state_next    = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!out_valid_reg || m_tready))
        else $error("commit while output word still held");
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DIFF)
        else $error("accepted word did not advance to difference step");
    a_late_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_LATE |-> $past(state_reg) == ST_DIFF)
        else $error("lateness step out of order");
    a_valid_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg) == ST_COMMIT)
        else $error("output valid raised without commit");
`endif

endmodule

>>> rtl/tdm_datapath.sv
// ----------------------------------------------------------------------------
// tdm_datapath
// Per-task statistics table, deadline registers, time arithmetic and
// output word register.
// ----------------------------------------------------------------------------
module tdm_datapath
    import tdm_pkg::*;
#(
    parameter int NUM_TASKS = NUM_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DEADLINE_W-1:0] cfg_data,
    input  logic [FUNC_W-1:0]     func,
    input  logic [TASK_W-1:0]     task_id,
    input  logic [TIME_BITS-1:0]  now_time,
    input  logic [TIME_BITS-1:0]  release_time,
    input  cmd_t                  cmd,
    output logic [TASK_W-1:0]     task_num,
    output logic                  job_ended,
    output logic [STAT_W-1:0]     job_count,
    output logic [STAT_W-1:0]     miss_count,
    output logic [STAT_W-1:0]     longest_run,
    output logic [STAT_W-1:0]     largest_overrun
);

    localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

    logic [DEADLINE_W-1:0] deadline_reg [NUM_TASKS];
    logic                  active_reg   [NUM_TASKS];
    logic [TIME_BITS-1:0]  start_reg    [NUM_TASKS];
    logic [TIME_BITS-1:0]  rel_reg      [NUM_TASKS];
    logic [STAT_W-1:0]     jobs_reg     [NUM_TASKS];
    logic [STAT_W-1:0]     miss_reg     [NUM_TASKS];
    logic [STAT_W-1:0]     exec_reg     [NUM_TASKS];
    logic [STAT_W-1:0]     late_reg     [NUM_TASKS];

    func_t                 func_reg;
    logic [TASK_W-1:0]     task_reg;
    logic [TIME_BITS-1:0]  now_reg;
    logic [TIME_BITS-1:0]  rel_in_reg;

    logic                  exec_ok_reg;
    logic [STAT_W-1:0]     exec_sat_reg;
    logic                  rel_ok_reg;
    logic [TIME_BITS-1:0]  rdiff_reg;
    logic                  late_ok_reg;
    logic [STAT_W-1:0]     late_sat_reg;

    logic [TASK_W-1:0]     out_task_reg;
    logic                  out_ended_reg;
    logic [STAT_W-1:0]     out_jobs_reg;
    logic [STAT_W-1:0]     out_miss_reg;
    logic [STAT_W-1:0]     out_exec_reg;
    logic [STAT_W-1:0]     out_late_reg;

    logic [IDX_W-1:0]      idx;
    logic                  in_range;
    logic [TIME_BITS-1:0]  exec_diff;
    logic [TIME_BITS-1:0]  late_diff;
    logic [TIME_BITS-1:0]  dl_ext;
    logic                  do_begin;
    logic                  do_end;
    logic                  do_clear;
    logic [STAT_W-1:0]     jobs_new;
    logic [STAT_W-1:0]     miss_new;
    logic [STAT_W-1:0]     exec_new;
    logic [STAT_W-1:0]     late_new;
    logic                  ended_val;
    logic [STAT_W-1:0]     jobs_val;
    logic [STAT_W-1:0]     miss_val;
    logic [STAT_W-1:0]     exec_val;
    logic [STAT_W-1:0]     late_val;

    assign idx      = task_reg[IDX_W-1:0];
    assign in_range = {1'b0, task_reg} < (TASK_W+1)'(NUM_TASKS);
    assign dl_ext   = TIME_BITS'(deadline_reg[idx]);

    assign exec_diff = now_reg - start_reg[idx];
    assign late_diff = rdiff_reg - dl_ext;

    always_comb
    begin
        do_begin = 1'b0;
        do_end   = 1'b0;
        do_clear = 1'b0;
        unique case (func_reg)
            FUNC_BEGIN: do_begin = in_range;
            FUNC_END:   do_end   = in_range && active_reg[idx];
            FUNC_CLEAR: do_clear = in_range;
            FUNC_NONE:  ;
            default:    ;
        endcase
    end

    always_comb
    begin
        jobs_new = (jobs_reg[idx] != STAT_MAX) ? jobs_reg[idx] + 1'b1 : jobs_reg[idx];
        miss_new = (late_ok_reg && miss_reg[idx] != STAT_MAX) ?
                   miss_reg[idx] + 1'b1 : miss_reg[idx];
        exec_new = (exec_ok_reg && exec_sat_reg > exec_reg[idx]) ?
                   exec_sat_reg : exec_reg[idx];
        late_new = (late_ok_reg && late_sat_reg > late_reg[idx]) ?
                   late_sat_reg : late_reg[idx];
        ended_val = 1'b0;
        jobs_val  = '0;
        miss_val  = '0;
        exec_val  = '0;
        late_val  = '0;
        if (in_range && !do_clear)
        begin
            if (do_end)
            begin
                ended_val = 1'b1;
                jobs_val  = jobs_new;
                miss_val  = miss_new;
                exec_val  = exec_new;
                late_val  = late_new;
            end
            else
            begin
                jobs_val = jobs_reg[idx];
                miss_val = miss_reg[idx];
                exec_val = exec_reg[idx];
                late_val = late_reg[idx];
            end
        end
    end

    // deadline registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                deadline_reg[i] <= DEADLINE_RESET[i];
            end
        end
        else if (cfg_we)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                if (i < NUM_DEADLINES && {1'b0, cfg_addr} == (CFG_ADDR_W+1)'(i))
                begin
                    deadline_reg[i] <= cfg_data;
                end
            end
        end
    end

    // per-task table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_TASKS; i++)
            begin
                active_reg[i] <= 1'b0;
                start_reg[i]  <= '0;
                rel_reg[i]    <= '0;
                jobs_reg[i]   <= '0;
                miss_reg[i]   <= '0;
                exec_reg[i]   <= '0;
                late_reg[i]   <= '0;
            end
        end
        else if (cmd.commit)
        begin
            if (do_clear)
            begin
                for (int i = 0; i < NUM_TASKS; i++)
                begin
                    active_reg[i] <= 1'b0;
                    start_reg[i]  <= '0;
                    rel_reg[i]    <= '0;
                    jobs_reg[i]   <= '0;
                    miss_reg[i]   <= '0;
                    exec_reg[i]   <= '0;
                    late_reg[i]   <= '0;
                end
            end
            else if (do_begin)
            begin
                active_reg[idx] <= 1'b1;
                start_reg[idx]  <= now_reg;
                rel_reg[idx]    <= rel_in_reg;
            end
            else if (do_end)
            begin
                active_reg[idx] <= 1'b0;
                jobs_reg[idx]   <= jobs_new;
                miss_reg[idx]   <= miss_new;
                exec_reg[idx]   <= exec_new;
                late_reg[idx]   <= late_new;
            end
        end
    end

    // event capture, arithmetic steps and output word load
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg   <= func_t'(func);
            task_reg   <= task_id;
            now_reg    <= now_time;
            rel_in_reg <= release_time;
        end
        if (cmd.calc_diff)
        begin
            exec_ok_reg  <= now_reg > start_reg[idx];
            exec_sat_reg <= sat32(64'(exec_diff));
            rel_ok_reg   <= now_reg > rel_reg[idx];
            rdiff_reg    <= now_reg - rel_reg[idx];
        end
        if (cmd.calc_late)
        begin
            late_ok_reg  <= rel_ok_reg && (rdiff_reg > dl_ext);
            late_sat_reg <= sat32(64'(late_diff));
        end
        if (cmd.commit)
        begin
            out_task_reg  <= task_reg;
            out_ended_reg <= ended_val;
            out_jobs_reg  <= jobs_val;
            out_miss_reg  <= miss_val;
            out_exec_reg  <= exec_val;
            out_late_reg  <= late_val;
        end
    end

    assign task_num        = out_task_reg;
    assign job_ended       = out_ended_reg;
    assign job_count       = out_jobs_reg;
    assign miss_count      = out_miss_reg;
    assign longest_run     = out_exec_reg;
    assign largest_overrun = out_late_reg;

`ifndef SYNTHESIS
    a_end_counts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && do_end && jobs_reg[idx] != STAT_MAX) |=>
        jobs_reg[$past(idx)] == $past(jobs_reg[idx]) + 1'b1)
        else $error("closed job not counted");
    a_miss_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && ended_val) |-> miss_val <= jobs_val)
        else $error("miss count exceeds job count");
    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && !in_range) |-> (!ended_val && jobs_val == '0 && late_val == '0))
        else $error("out of range task reported statistics");
`endif

endmodule
